[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/gcs_pkg.sv]
// ----------------------------------------------------------------------------
// gcs_pkg
// Types and constant tables for the consensus genotype selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcs_pkg;

    localparam int NumGeno = 10;

    typedef logic [7:0]  t_lik;
    typedef logic [9:0]  t_penalty;
    typedef logic [10:0] t_score;
    typedef logic [3:0]  t_mask;
    typedef logic [3:0]  t_rank;

    // Base mask per genotype in scan order AA AC AG AT CC CG CT GG GT TT.
    localparam t_mask GenoMask [NumGeno] = '{
        4'h1, 4'h3, 4'h5, 4'h9, 4'h2, 4'h6, 4'hA, 4'h4, 4'hC, 4'h8
    };

    // Heterozygous genotypes (bit i set for scan position i).
    localparam logic [NumGeno-1:0] GenoHet = 10'b0101101110;

    localparam t_mask    NoCallMask      = 4'hF;
    localparam t_lik     GapMax          = 8'd255;
    localparam t_penalty HetPenaltyReset = 10'd27;

endpackage

[rtl/genotype_consensus_select_core.sv]
// ----------------------------------------------------------------------------
// genotype_consensus_select_core
// Picks the best and second diploid genotype of a site and their gaps.
// ----------------------------------------------------------------------------
// The core takes one site item per cycle and returns one result item per
// site, in order, and keeps that intake rate only while its output is not
// stalled. Each accepted item is captured in an input register; between
// that register and the result register a network of score comparators
// ranks all ten penalized scores at once, and the genotypes ranked first and
// second plus the first three scores are selected from the ranks. That
// comparator network is the one path that sets the clock, and it is fully
// repeated per cycle, so throughput is one item per cycle. Backpressure on
// the result channel propagates to o_ready through the two pipeline stages.
// The heterozygote penalty register resets to 27 and is written through its
// own channel, which is always ready; write it only while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module genotype_consensus_select_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // site items
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_has_reads,
    input  gcs_pkg::t_lik     i_lik_aa,
    input  gcs_pkg::t_lik     i_lik_ac,
    input  gcs_pkg::t_lik     i_lik_ag,
    input  gcs_pkg::t_lik     i_lik_at,
    input  gcs_pkg::t_lik     i_lik_cc,
    input  gcs_pkg::t_lik     i_lik_cg,
    input  gcs_pkg::t_lik     i_lik_ct,
    input  gcs_pkg::t_lik     i_lik_gg,
    input  gcs_pkg::t_lik     i_lik_gt,
    input  gcs_pkg::t_lik     i_lik_tt,
    input  gcs_pkg::t_lik     i_map_quality_in,
    // result items
    output logic              o_valid,
    input  logic              i_ready,
    output gcs_pkg::t_mask    o_best_genotype,
    output gcs_pkg::t_mask    o_second_genotype,
    output gcs_pkg::t_lik     o_map_quality_out,
    output gcs_pkg::t_lik     o_consensus_quality,
    output gcs_pkg::t_lik     o_snp_quality,
    // configuration: heterozygote penalty
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  gcs_pkg::t_penalty i_cfg_data
);
    import gcs_pkg::*;

    // ---------------- configuration ----------------
    t_penalty r_het_penalty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_het_penalty <= HetPenaltyReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_het_penalty <= i_cfg_data;
        end
    end

    // ---------------- pipeline control ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic w_s1_load;
    logic w_s2_ready;
    logic w_out_load;

    // Result stage frees up when empty or when its item leaves this cycle.
    assign w_s2_ready = !r_out_valid || i_ready;
    assign o_ready    = !r_s1_valid || w_s2_ready;
    assign w_s1_load  = i_valid && o_ready;
    assign w_out_load = r_s1_valid && w_s2_ready;
    assign o_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Hold the input stage while the result stage is stalled.
            if (w_s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (w_s2_ready) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // ---------------- input register ----------------
    logic r_has_reads;
    t_lik r_lik [NumGeno];
    t_lik r_map_quality;

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_has_reads   <= i_has_reads;
            r_lik[0]      <= i_lik_aa;
            r_lik[1]      <= i_lik_ac;
            r_lik[2]      <= i_lik_ag;
            r_lik[3]      <= i_lik_at;
            r_lik[4]      <= i_lik_cc;
            r_lik[5]      <= i_lik_cg;
            r_lik[6]      <= i_lik_ct;
            r_lik[7]      <= i_lik_gg;
            r_lik[8]      <= i_lik_gt;
            r_lik[9]      <= i_lik_tt;
            r_map_quality <= i_map_quality_in;
        end
    end

    // ---------------- ranking network ----------------
    t_score             w_score [NumGeno];
    t_rank              w_rank  [NumGeno];
    logic [NumGeno-1:0] w_first_sel;
    t_mask              w_mask1;
    t_mask              w_mask2;
    t_score             w_s1;
    t_score             w_s2;
    t_score             w_s3;
    t_score             w_gap12;
    t_score             w_gap23;

    // Apply the heterozygote penalty; scores cannot overflow 11 bits.
    always_comb begin
        for (int i = 0; i < NumGeno; i++) begin
            w_score[i] = {3'b000, r_lik[i]}
                       + (GenoHet[i] ? {1'b0, r_het_penalty} : '0);
        end
    end

    // Rank of a genotype = number of genotypes ahead of it: a smaller score,
    // or an equal score earlier in scan order.
    always_comb begin
        for (int i = 0; i < NumGeno; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < NumGeno; j++) begin
                if (j != i) begin
                    w_rank[i] = w_rank[i] + t_rank'((w_score[j] < w_score[i])
                        || ((w_score[j] == w_score[i]) && (j < i)));
                end
            end
        end
    end

    // Ranks are a permutation, so each rank picks exactly one genotype.
    always_comb begin
        w_mask1     = '0;
        w_mask2     = '0;
        w_s1        = '0;
        w_s2        = '0;
        w_s3        = '0;
        w_first_sel = '0;
        for (int i = 0; i < NumGeno; i++) begin
            if (w_rank[i] == t_rank'(0)) begin
                w_first_sel[i] = 1'b1;
                w_mask1        = w_mask1 | GenoMask[i];
                w_s1           = w_s1 | w_score[i];
            end
            if (w_rank[i] == t_rank'(1)) begin
                w_mask2 = w_mask2 | GenoMask[i];
                w_s2    = w_s2 | w_score[i];
            end
            if (w_rank[i] == t_rank'(2)) begin
                w_s3 = w_s3 | w_score[i];
            end
        end
    end

    assign w_gap12 = w_s2 - w_s1;
    assign w_gap23 = w_s3 - w_s2;

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_has_reads) begin
                o_best_genotype     <= w_mask1;
                o_second_genotype   <= w_mask2;
                o_map_quality_out   <= r_map_quality;
                // Saturate the gaps to one byte.
                o_consensus_quality <= (w_gap12 > t_score'(GapMax)) ? GapMax
                                                                     : w_gap12[7:0];
                o_snp_quality       <= (w_gap23 > t_score'(GapMax)) ? GapMax
                                                                     : w_gap23[7:0];
            end else begin
                // No reads: no-call masks, zero qualities.
                o_best_genotype     <= NoCallMask;
                o_second_genotype   <= NoCallMask;
                o_map_quality_out   <= '0;
                o_consensus_quality <= '0;
                o_snp_quality       <= '0;
            end
        end
    end

    // ---------------- assertions ----------------
    `ASSERT_IMP(a_one_best, i_clk, i_rst_n, r_s1_valid && r_has_reads,
        $onehot(w_first_sel), "best genotype select is not one-hot")
    `ASSERT_IMP(a_nocall_whole, i_clk, i_rst_n,
        o_valid && (o_best_genotype == NoCallMask),
        (o_second_genotype == NoCallMask) && (o_map_quality_out == 8'd0)
            && (o_consensus_quality == 8'd0) && (o_snp_quality == 8'd0),
        "no-call result with nonzero fields")
    `ASSERT_IMP(a_distinct_calls, i_clk, i_rst_n,
        o_valid && (o_best_genotype != NoCallMask),
        o_second_genotype != o_best_genotype,
        "best and second genotype coincide")
    `ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, i_valid && o_ready,
        r_s1_valid, "accepted item lost from input stage")

endmodule

[bench/genotype_consensus_select_core_test.sv]
// ----------------------------------------------------------------------------
// genotype_consensus_select_core_test
// Self-checking bench for the consensus genotype selector.
// ----------------------------------------------------------------------------
// A short table of hand-picked site items runs first, under the reset
// penalty. It covers no-call sites, all-equal and extreme scores, each
// genotype as the lone minimum, and ties broken by scan order. Rows whose
// call is obvious carry their expected call; every other row and all random
// site items are checked against a scoreboard model of the selector. The
// random part runs in phases, one penalty per phase with both extremes
// among them. Both sides insert random gaps, and two phases hold the result
// side off long enough to back the core up to its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module genotype_consensus_select_core_test;

    import gcs_pkg::*;

    localparam int NumDirected  = 22;
    localparam int ItemsPerPass = 100;
    localparam int NumPasses    = 8;

    // One called site, as the result channel carries it.
    typedef struct packed {
        t_mask best;
        t_mask second;
        t_lik  mapq;
        t_lik  cons_q;
        t_lik  snp_q;
    } site_call_t;

    // Scores are packed TT in the top byte down to AA in the bottom byte, so
    // genotype g in scan order sits at scores[8*g +: 8].
    typedef struct packed {
        logic        has_reads;
        logic [79:0] scores;
        t_lik        mapq;
        logic        typed;
        site_call_t  call;
    } site_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_has_reads;
    logic [79:0] scores_drv;
    t_lik       i_map_quality_in;
    logic       o_valid;
    logic       i_ready;
    t_mask      o_best_genotype;
    t_mask      o_second_genotype;
    t_lik       o_map_quality_out;
    t_lik       o_consensus_quality;
    t_lik       o_snp_quality;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_penalty   i_cfg_data;

    // Expected calls, oldest first, and the penalty the core now holds.
    site_call_t calls_pending [$];
    t_penalty   het_penalty_now;
    int         bad_count;
    bit         gaps_on;
    int         sink_hold_cycles;

    // Directed site items; penalty is still at its reset value here.
    site_row_t dir_rows [NumDirected] = '{
        // no reads: no-call whatever the scores
        '{1'b0, 80'hFF_FF_FF_FF_FF_FF_FF_FF_FF_FF, 8'hC8, 1'b1,
          '{NoCallMask, NoCallMask, 8'h00, 8'h00, 8'h00}},
        '{1'b0, 80'h00_00_00_00_00_00_00_00_00_00, 8'hFF, 1'b1,
          '{NoCallMask, NoCallMask, 8'h00, 8'h00, 8'h00}},
        // all scores zero: homozygous AA, CC, GG, TT tie, hets pushed back
        '{1'b1, 80'h00_00_00_00_00_00_00_00_00_00, 8'h00, 1'b1,
          '{4'h1, 4'h2, 8'h00, 8'h00, 8'h00}},
        // all scores at top: same order, mapping quality at top
        '{1'b1, 80'hFF_FF_FF_FF_FF_FF_FF_FF_FF_FF, 8'hFF, 1'b1,
          '{4'h1, 4'h2, 8'hFF, 8'h00, 8'h00}},
        // lone AA at zero: first gap saturates
        '{1'b1, 80'hFF_FF_FF_FF_FF_FF_FF_FF_FF_00, 8'h3C, 1'b1,
          '{4'h1, 4'h2, 8'h3C, 8'hFF, 8'h00}},
        // lone TT at zero: last in scan order still wins
        '{1'b1, 80'h00_FF_FF_FF_FF_FF_FF_FF_FF_FF, 8'h55, 1'b1,
          '{4'h8, 4'h1, 8'h55, 8'hFF, 8'h00}},
        // lone AC at zero: wins at the penalty, gap 255 - 27
        '{1'b1, 80'hFF_FF_FF_FF_FF_FF_FF_FF_00_FF, 8'hAA, 1'b1,
          '{4'h3, 4'h1, 8'hAA, 8'hE4, 8'h00}},
        // each genotype as the lone minimum
        '{1'b1, 80'hC8_C8_C8_C8_C8_C8_C8_C8_C8_00, 8'h01, 1'b0, '0},
        '{1'b1, 80'hC8_C8_C8_C8_C8_C8_C8_C8_00_C8, 8'h02, 1'b0, '0},
        '{1'b1, 80'hC8_C8_C8_C8_C8_C8_C8_00_C8_C8, 8'h04, 1'b0, '0},
        '{1'b1, 80'hC8_C8_C8_C8_C8_C8_00_C8_C8_C8, 8'h08, 1'b0, '0},
        '{1'b1, 80'hC8_C8_C8_C8_C8_00_C8_C8_C8_C8, 8'h10, 1'b0, '0},
        '{1'b1, 80'hC8_C8_C8_C8_00_C8_C8_C8_C8_C8, 8'h20, 1'b0, '0},
        '{1'b1, 80'hC8_C8_C8_00_C8_C8_C8_C8_C8_C8, 8'h40, 1'b0, '0},
        '{1'b1, 80'hC8_C8_00_C8_C8_C8_C8_C8_C8_C8, 8'h80, 1'b0, '0},
        '{1'b1, 80'hC8_00_C8_C8_C8_C8_C8_C8_C8_C8, 8'hFE, 1'b0, '0},
        '{1'b1, 80'h00_C8_C8_C8_C8_C8_C8_C8_C8_C8, 8'h7F, 1'b0, '0},
        // AA and CC tie low: earlier one ranks first, gap zero
        '{1'b1, 80'hFF_FF_FF_FF_FF_05_FF_FF_FF_05, 8'h33, 1'b0, '0},
        // scores falling along scan order
        '{1'b1, 80'h00_1C_38_54_70_8C_A8_C4_E0_FC, 8'hCC, 1'b0, '0},
        '{1'b1, 80'h5A_A5_3C_C3_0F_F0_96_69_81_7E, 8'h81, 1'b0, '0},
        // penalized AC ties AA exactly: AA ranks first
        '{1'b1, 80'hFF_FF_FF_FF_FF_FF_FF_FF_00_1B, 8'h18, 1'b0, '0},
        '{1'b0, 80'h12_34_56_78_9A_BC_DE_F0_0F_AA, 8'h7E, 1'b1,
          '{NoCallMask, NoCallMask, 8'h00, 8'h00, 8'h00}}
    };

    genotype_consensus_select_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_has_reads         (i_has_reads),
        .i_lik_aa            (scores_drv[7:0]),
        .i_lik_ac            (scores_drv[15:8]),
        .i_lik_ag            (scores_drv[23:16]),
        .i_lik_at            (scores_drv[31:24]),
        .i_lik_cc            (scores_drv[39:32]),
        .i_lik_cg            (scores_drv[47:40]),
        .i_lik_ct            (scores_drv[55:48]),
        .i_lik_gg            (scores_drv[63:56]),
        .i_lik_gt            (scores_drv[71:64]),
        .i_lik_tt            (scores_drv[79:72]),
        .i_map_quality_in    (i_map_quality_in),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_best_genotype     (o_best_genotype),
        .o_second_genotype   (o_second_genotype),
        .o_map_quality_out   (o_map_quality_out),
        .o_consensus_quality (o_consensus_quality),
        .o_snp_quality       (o_snp_quality),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Base mask of genotype g in scan order; two bits set marks a het.
    function automatic t_mask base_mask(int g);
        case (g)
            0:       return 4'h1;
            1:       return 4'h3;
            2:       return 4'h5;
            3:       return 4'h9;
            4:       return 4'h2;
            5:       return 4'h6;
            6:       return 4'hA;
            7:       return 4'h4;
            8:       return 4'hC;
            default: return 4'h8;
        endcase
    endfunction

    function automatic bit is_het(int g);
        t_mask m;
        m = base_mask(g);
        return (m & (m - 4'h1)) != 4'h0;
    endfunction

    function automatic t_lik clip_gap(logic [10:0] hi, logic [10:0] lo);
        logic [10:0] d;
        d = hi - lo;
        return (d > 11'd255) ? 8'hFF : d[7:0];
    endfunction

    // Call one site: penalize hets, keep the three smallest in scan order.
    function automatic site_call_t call_site(logic has_reads, logic [79:0] scores,
                                             t_lik mapq, t_penalty pen);
        site_call_t  c;
        logic [10:0] s, s1, s2, s3;
        int          g1, g2;
        if (!has_reads) begin
            c = '{NoCallMask, NoCallMask, 8'h00, 8'h00, 8'h00};
            return c;
        end
        // Start above any reachable score (255 + 1023) so all ten rank.
        s1 = '1;
        s2 = '1;
        s3 = '1;
        g1 = 0;
        g2 = 0;
        for (int g = 0; g < NumGeno; g++) begin
            s = {3'b000, scores[8*g +: 8]} + (is_het(g) ? {1'b0, pen} : 11'd0);
            if (s < s1) begin
                s3 = s2; s2 = s1; s1 = s;
                g2 = g1; g1 = g;
            end else if (s < s2) begin
                s3 = s2; s2 = s;
                g2 = g;
            end else if (s < s3) begin
                s3 = s;
            end
        end
        c.best   = base_mask(g1);
        c.second = base_mask(g2);
        c.mapq   = mapq;
        c.cons_q = clip_gap(s2, s1);
        c.snp_q  = clip_gap(s3, s2);
        return c;
    endfunction

    // Draw a score set; most shapes crowd the scores to stress ranking.
    function automatic logic [79:0] draw_scores(t_penalty pen);
        logic [79:0] v;
        int          shape;
        int          base;
        int          t;
        shape = $urandom_range(0, 4);
        base  = $urandom_range(0, 255);
        for (int g = 0; g < NumGeno; g++) begin
            case (shape)
                0: t = $urandom_range(0, 255);
                1: t = base + $urandom_range(0, 3) - 2;
                2: t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 255;
                3: t = base;
                // hets offset by the penalty, so penalized scores collide
                default: t = base + $urandom_range(0, 2) - (is_het(g) ? int'(pen) : 0);
            endcase
            if (t < 0)   t = 0;
            if (t > 255) t = 255;
            v[8*g +: 8] = t[7:0];
        end
        return v;
    endfunction

    task automatic flag_error(string msg);
        bad_count++;
        if (bad_count <= 10) $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            flag_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    endtask

    // Offer one site item, hold it until accepted, and queue its call.
    // Entered and left at a falling edge.
    task automatic send_site(logic has_reads, logic [79:0] scores, t_lik mapq,
                             logic typed, site_call_t typed_call);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_has_reads      = has_reads;
        scores_drv       = scores;
        i_map_quality_in = mapq;
        i_valid          = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        calls_pending.push_back(typed ? typed_call
                                      : call_site(has_reads, scores, mapq, het_penalty_now));
        @(negedge i_clk);
    endtask

    // Pause the source until every queued call has come back.
    task automatic drain_calls();
        i_valid = 1'b0;
        while (calls_pending.size() != 0) @(negedge i_clk);
    endtask

    // Write the penalty; only called with the core drained.
    task automatic write_het_penalty(t_penalty value);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        het_penalty_now = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Result side: random stall per item, or a long hold when requested.
    initial begin : sink
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                i_ready = 1'b0;
                repeat (sink_hold_cycles) @(negedge i_clk);
                sink_hold_cycles = 0;
            end
            stall = gaps_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // Compare each accepted result item with the oldest expected call.
    always @(posedge i_clk) begin
        site_call_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (calls_pending.size() == 0) begin
                flag_error($sformatf("result item with nothing expected: best %h second %h",
                                     o_best_genotype, o_second_genotype));
            end else begin
                want = calls_pending.pop_front();
                check_field("best_genotype",     {4'h0, want.best},
                            {4'h0, o_best_genotype});
                check_field("second_genotype",   {4'h0, want.second},
                            {4'h0, o_second_genotype});
                check_field("map_quality_out",   want.mapq,   o_map_quality_out);
                check_field("consensus_quality", want.cons_q, o_consensus_quality);
                check_field("snp_quality",       want.snp_q,  o_snp_quality);
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        t_penalty pen;
        int       wait_cycles;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_has_reads      = 1'b0;
        scores_drv       = '0;
        i_map_quality_in = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        het_penalty_now  = HetPenaltyReset;
        bad_count        = 0;
        gaps_on          = 1'b1;
        sink_hold_cycles = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed rows under the reset penalty.
        for (int r = 0; r < NumDirected; r++) begin
            send_site(dir_rows[r].has_reads, dir_rows[r].scores, dir_rows[r].mapq,
                      dir_rows[r].typed, dir_rows[r].call);
        end

        // Random passes, one penalty each; extremes first.
        for (int p = 0; p < NumPasses; p++) begin
            drain_calls();
            case (p)
                0:       pen = 10'd0;
                1:       pen = 10'd1023;
                2:       pen = 10'd255;
                3:       pen = 10'd1;
                4:       pen = HetPenaltyReset;
                default: pen = t_penalty'($urandom_range(0, 1023));
            endcase
            write_het_penalty(pen);
            // Passes 2 and 5 run back to back with no gaps on either side.
            gaps_on = (p % 3) != 2;
            // Hold the result side so the core backs up into its input.
            if (p == 1 || p == 5) sink_hold_cycles = 40 + $urandom_range(0, 20);
            for (int n = 0; n < ItemsPerPass; n++) begin
                send_site($urandom_range(0, 9) != 0, draw_scores(pen),
                          t_lik'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        i_valid = 1'b0;
        wait_cycles = 0;
        while (calls_pending.size() != 0 && wait_cycles < 2000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        // Let any stray result item surface before the verdict.
        repeat (10) @(negedge i_clk);
        if (calls_pending.size() != 0)
            flag_error($sformatf("%0d expected result items never came",
                                 calls_pending.size()));

        if (bad_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/gcs_pkg.sv
rtl/genotype_consensus_select_core.sv
bench/genotype_consensus_select_core_test.sv
